/* src/wildcard_pattern_matcher_top_defines.svh */
// Assertion macros shared by the wildcard matcher checker.
`ifndef WILDCARD_PATTERN_MATCHER_TOP_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define WPM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wildcard matcher check failed");

// Next-cycle implication, sampled on clk, off during reset
`define WPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wildcard matcher check failed");

`endif

/* src/wpm_pkg.sv */
// Types, constants and codes for the wildcard pattern matcher.
package wpm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int COL_N       = MAX_PATTERN + 1;
    localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
    localparam int ADDR_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam logic [7:0] STAR_CHAR = 8'd42;
    localparam logic [7:0] ANY_CHAR  = 8'd63;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TEXT   = 2'd2;
    localparam logic [1:0] OP_BEGIN  = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_value;
    } req_t;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic step;
        logic emit;
    } wpm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic out_free;
    } wpm_status_t;

endpackage

/* src/wildcard_pattern_matcher_top.sv */
// Top level of the wildcard pattern matcher.
//
//   channel   handshake                 payload   direction
//   request   req_valid / req_stall     req       in
//   result    rsp_valid / rsp_stall     rsp       out
//
// Clear and append are taken while idle and give no result.
// Begin text and text characters sweep the match row one column a cycle through
// the single pattern memory read port, over all MAX_PATTERN + 1 columns, then load
// the result register; a new request waits until the result is loaded.
// Reset is asynchronous and active low; it empties the pattern and sets column zero.
// A stalled result is held while requests are still taken until the next sweep ends.
module wildcard_pattern_matcher_top
    import wpm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    wpm_cmd_t    cmd;
    wpm_status_t status;

    wpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .opcode    (req.opcode),
        .status    (status),
        .req_stall (req_stall),
        .cmd       (cmd)
    );

    wpm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .rsp_stall (rsp_stall),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

/* src/wpm_ctrl.sv */
// Controller: sequences the column sweep and the result hand-off.
module wpm_ctrl
    import wpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic [1:0]  opcode,
    input  wpm_status_t status,
    output logic        req_stall,
    output wpm_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_HOLD  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       sweep_op;

    assign sweep_op  = (opcode == OP_TEXT) || (opcode == OP_BEGIN);
    assign req_stall = (state_reg != S_IDLE);

    // Decide the next state and the commands for this cycle
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sweep_op)
                        state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                cmd.step = 1'b1;
                if (status.sweep_last)
                    state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* src/wpm_datapath.sv */
// Datapath: pattern memory, match row shift line, sweep counter, result register.
module wpm_datapath
    import wpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  req_t        req,
    input  wpm_cmd_t    cmd,
    input  logic        rsp_stall,
    output wpm_status_t status,
    output logic        rsp_valid,
    output rsp_t        rsp
);

    logic [7:0]       pat_mem [MAX_PATTERN];
    logic [7:0]       rd_data_reg;

    logic [CNT_W-1:0] count_reg;
    logic             ovf_reg;
    logic [COL_N-1:0] row_reg;
    logic [CNT_W-1:0] col_reg;
    logic             begin_reg;
    logic [7:0]       ch_reg;
    logic             prev_old_reg;
    logic             prev_new_reg;
    logic             hit_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    logic             old_bit;
    logic             new_bit;
    logic             pc_star;
    logic             pc_hit;
    logic             room;

    assign room    = (count_reg < CNT_W'(MAX_PATTERN));
    assign old_bit = row_reg[0];
    assign pc_star = (rd_data_reg == STAR_CHAR);
    assign pc_hit  = (rd_data_reg == ANY_CHAR) || (rd_data_reg == ch_reg);

    // Work out the new value of the column now at the head of the shift line
    always_comb
    begin
        priority if (col_reg == '0)
            new_bit = begin_reg;
        else if (col_reg > count_reg)
            new_bit = 1'b0;
        else if (begin_reg)
            new_bit = prev_new_reg & pc_star;
        else if (pc_star)
            new_bit = old_bit | prev_new_reg;
        else if (pc_hit)
            new_bit = prev_old_reg;
        else
            new_bit = 1'b0;
    end

    assign status.sweep_last = (col_reg == CNT_W'(MAX_PATTERN));
    assign status.out_free   = !rsp_valid_reg || !rsp_stall;

    // Store appended pattern characters and read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (req.opcode == OP_APPEND) && room)
            pat_mem[count_reg[ADDR_W-1:0]] <= req.char_value;
        rd_data_reg <= pat_mem[col_reg[ADDR_W-1:0]];
    end

    // Pattern length, overflow flag and the match row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            row_reg   <= COL_N'(1);
            col_reg   <= '0;
        end
        else if (cmd.accept)
        begin
            col_reg <= '0;
            unique case (req.opcode)
                OP_CLEAR:
                begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                    row_reg   <= COL_N'(1);
                end
                OP_APPEND:
                begin
                    // Columns above the count are always zero, so the new one is too
                    if (room)
                        count_reg <= count_reg + CNT_W'(1);
                    else
                        ovf_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.step)
        begin
            // Rotate the row by one column, writing the new value at the tail
            row_reg <= {new_bit, row_reg[COL_N-1:1]};
            col_reg <= col_reg + CNT_W'(1);
        end
    end

    // Latch the request and carry neighbor values along the sweep
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            begin_reg <= (req.opcode == OP_BEGIN);
            ch_reg    <= req.char_value;
        end
        if (cmd.step)
        begin
            prev_old_reg <= old_bit;
            prev_new_reg <= new_bit;
            if (col_reg == count_reg)
                hit_reg <= new_bit;
        end
        if (cmd.emit)
        begin
            rsp_reg.matched          <= hit_reg;
            rsp_reg.pattern_overflow <= ovf_reg;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.emit)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* src/wpm_checker.sv */
// Port-level checker for the wildcard pattern matcher, with its bind.
`include "wildcard_pattern_matcher_top_defines.svh"

module wpm_checker
    import wpm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    logic acc;

    assign acc = req_valid && !req_stall;

    // A stalled result stays put
    `WPM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // A text or begin request starts a sweep, so the next request waits
    `WPM_ASSERT_NEXT(a_sweep_busy, acc && (req.opcode == OP_TEXT || req.opcode == OP_BEGIN),
        req_stall)

    // Clear and append finish at once
    `WPM_ASSERT_NEXT(a_quick_ops, acc && (req.opcode == OP_CLEAR || req.opcode == OP_APPEND),
        !req_stall)

    // A new result appears only at the end of a sweep
    `WPM_ASSERT_NOW(a_rsp_after_sweep, $rose(rsp_valid), $past(req_stall))

endmodule

bind wildcard_pattern_matcher_top wpm_checker u_wpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

/* tb/wildcard_pattern_matcher_top_test.sv */
// Self-checking testbench for the wildcard pattern matcher top level.
module wildcard_pattern_matcher_top_test;
    import wpm_pkg::*;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Idle rates in percent for each side
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // Mirror of the matcher state
    logic [7:0]       pattern_chars [MAX_PATTERN];
    int               pattern_len;
    bit [COL_N-1:0]   prefix_hits;
    bit               overflow_flag;

    rsp_t expected_results [$];
    int   mismatch_count = 0;
    int   requests_sent  = 0;

    wildcard_pattern_matcher_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Apply one request to the mirrored row; return 1 when it yields a result
    function automatic bit match_request(input req_t r, output rsp_t o);
        bit prev_old;
        bit old_bit;
        bit new_bit;
        o = '0;
        case (r.opcode)
            OP_CLEAR:
            begin
                pattern_len    = 0;
                overflow_flag  = 1'b0;
                prefix_hits    = '0;
                prefix_hits[0] = 1'b1;
                return 1'b0;
            end
            OP_APPEND:
            begin
                if (pattern_len < MAX_PATTERN)
                begin
                    pattern_chars[pattern_len] = r.char_value;
                    pattern_len++;
                    prefix_hits[pattern_len] = 1'b0;
                end
                else
                begin
                    overflow_flag = 1'b1;
                end
                return 1'b0;
            end
            OP_BEGIN:
            begin
                prefix_hits    = '0;
                prefix_hits[0] = 1'b1;
                for (int j = 1; j <= pattern_len; j++)
                    prefix_hits[j] = prefix_hits[j-1] && (pattern_chars[j-1] == STAR_CHAR);
            end
            default:
            begin
                prev_old       = prefix_hits[0];
                prefix_hits[0] = 1'b0;
                for (int j = 1; j <= pattern_len; j++)
                begin
                    old_bit = prefix_hits[j];
                    if (pattern_chars[j-1] == STAR_CHAR)
                        new_bit = old_bit | prefix_hits[j-1];
                    else if (pattern_chars[j-1] == ANY_CHAR || pattern_chars[j-1] == r.char_value)
                        new_bit = prev_old;
                    else
                        new_bit = 1'b0;
                    prefix_hits[j] = new_bit;
                    prev_old       = old_bit;
                end
            end
        endcase
        o.matched          = prefix_hits[pattern_len];
        o.pattern_overflow = overflow_flag;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Send one request; enter and leave at a falling edge with valid still high
    task automatic send_request(input logic [1:0] op, input logic [7:0] ch);
        req_t r;
        rsp_t o;
        r.opcode     = op;
        r.char_value = ch;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (match_request(r, o))
            expected_results.push_back(o);
        requests_sent++;
        @(negedge clk);
    endtask

    // Drive the result stall
    always @(negedge clk)
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %b", rsp));
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp.matched !== want.matched)
                    report_mismatch($sformatf("matched got %b want %b",
                                              rsp.matched, want.matched));
                if (rsp.pattern_overflow !== want.pattern_overflow)
                    report_mismatch($sformatf("pattern_overflow got %b want %b",
                                              rsp.pattern_overflow, want.pattern_overflow));
            end
        end
    end

    task automatic test_empty_pattern();
        send_request(OP_CLEAR, 8'h00);
        send_request(OP_BEGIN, 8'hFF);
        send_request(OP_TEXT, 8'h00);
    endtask

    task automatic test_literal_and_any();
        send_request(OP_CLEAR, 8'hFF);
        send_request(OP_APPEND, "a");
        send_request(OP_APPEND, ANY_CHAR);
        send_request(OP_APPEND, 8'hFF);
        send_request(OP_BEGIN, 8'h00);
        send_request(OP_TEXT, "a");
        send_request(OP_TEXT, 8'h00);
        send_request(OP_TEXT, 8'hFF);
        // Star in the text is only a literal byte
        send_request(OP_TEXT, STAR_CHAR);
    endtask

    task automatic test_star_runs();
        send_request(OP_CLEAR, 8'h00);
        send_request(OP_APPEND, STAR_CHAR);
        send_request(OP_APPEND, STAR_CHAR);
        send_request(OP_APPEND, "b");
        send_request(OP_BEGIN, 8'h00);
        send_request(OP_TEXT, "b");
        send_request(OP_TEXT, "x");
        send_request(OP_TEXT, "b");
    endtask

    task automatic test_extend_during_text();
        send_request(OP_BEGIN, 8'h00);
        send_request(OP_TEXT, "b");
        send_request(OP_APPEND, STAR_CHAR);
        send_request(OP_TEXT, "c");
        send_request(OP_BEGIN, 8'h00);
    endtask

    // Mostly well-formed pattern/text sequences, some noise
    task automatic test_random_sequences(input int n_items, input int unsigned send_pct,
                                         input int unsigned recv_pct);
        int         stop_at;
        int         seq_idx;
        int         pat_n;
        int         pick;
        logic [7:0] gen_pat  [$];
        logic [7:0] gen_text [$];
        logic [7:0] c;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at       = requests_sent + n_items;
        seq_idx       = 0;
        while (requests_sent < stop_at)
        begin
            seq_idx++;
            if ($urandom_range(99) < 10)
            begin
                // Noise: any opcode, any byte
                repeat ($urandom_range(4, 1))
                    send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
                continue;
            end
            if ($urandom_range(9) != 0)
                send_request(OP_CLEAR, 8'($urandom_range(255)));
            // Build a pattern; some runs go past capacity
            if (seq_idx == 1 || $urandom_range(24) == 0)
                pat_n = $urandom_range(MAX_PATTERN + 6, MAX_PATTERN - 4);
            else
                pat_n = $urandom_range(8);
            gen_pat.delete();
            repeat (pat_n)
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                    c = STAR_CHAR;
                else if (pick < 50)
                    c = ANY_CHAR;
                else if (pick < 90)
                    c = 8'("a" + $urandom_range(2));
                else
                    c = 8'($urandom_range(255));
                gen_pat.push_back(c);
                send_request(OP_APPEND, c);
            end
            repeat ($urandom_range(3, 1))
            begin
                // Derive a text that fits the pattern, then maybe break it
                gen_text.delete();
                foreach (gen_pat[i])
                begin
                    if (gen_pat[i] == STAR_CHAR)
                    begin
                        repeat ($urandom_range(3))
                            gen_text.push_back($urandom_range(1) ?
                                               8'("a" + $urandom_range(2)) :
                                               8'($urandom_range(255)));
                    end
                    else if (gen_pat[i] == ANY_CHAR)
                        gen_text.push_back(8'($urandom_range(255)));
                    else
                        gen_text.push_back(gen_pat[i]);
                end
                pick = $urandom_range(9);
                if (pick == 0 && gen_text.size() > 0)
                    gen_text[$urandom_range(gen_text.size() - 1)] = 8'($urandom_range(255));
                else if (pick == 1 && gen_text.size() > 0)
                    void'(gen_text.pop_back());
                else if (pick == 2)
                    gen_text.push_back(8'("a" + $urandom_range(2)));
                else if (pick == 3)
                    gen_text.push_front(8'($urandom_range(255)));
                send_request(OP_BEGIN, 8'($urandom_range(255)));
                foreach (gen_text[i])
                begin
                    // Occasionally grow the pattern mid-text
                    if ($urandom_range(99) < 4)
                        send_request(OP_APPEND, $urandom_range(1) ? STAR_CHAR
                                                                  : 8'($urandom_range(255)));
                    send_request(OP_TEXT, gen_text[i]);
                end
            end
        end
    endtask

    initial
    begin
        pattern_len    = 0;
        overflow_flag  = 1'b0;
        prefix_hits    = '0;
        prefix_hits[0] = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_pattern();
        test_literal_and_any();
        test_star_runs();
        test_extend_during_text();
        test_random_sequences(340, 12, 85);
        test_random_sequences(340, 85, 12);
        test_random_sequences(345, 0, 0);

        // Drain outstanding results, then watch for strays
        req_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2 * COL_N + 8) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hard stop on a hang
    initial
    begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
